// ----- rtl/fprf_pkg.sv -----
// shared types and constants for the false-position root finder
package fprf_pkg;

  localparam int FracBitsDefault = 28;
  localparam int PowerDefault    = 10;
  localparam int ValW  = 31;
  localparam int IterW = 8;
  localparam int TolW  = 30;
  localparam int StatW = 2;
  localparam int IdxW  = 1;
  localparam int CfgW  = 30;

  localparam logic [IterW-1:0] IterLimitReset = 8'd50;
  localparam logic [TolW-1:0]  TolReset       = 30'd268;

  localparam logic [IdxW-1:0] RegIterLimit = 1'b0;
  localparam logic [IdxW-1:0] RegTolerance = 1'b1;

  localparam logic [StatW-1:0] StTol   = 2'd0;
  localparam logic [StatW-1:0] StLimit = 2'd1;
  localparam logic [StatW-1:0] StExact = 2'd2;
  localparam logic [StatW-1:0] StZden  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_FL, S_FU, S_DEN, S_MUL, S_DGO, S_DIV, S_XR, S_FR, S_UPD, S_DONE
  } state_t;

  // request to the shared power unit
  typedef struct packed {
    logic        go;
    logic [63:0] mag;
  } pow_req_t;

endpackage

// ----- rtl/fprf_mulq.sv -----
// sequential magnitude power unit: x^power with truncating saturating multiplies
module fprf_mulq #(
  parameter int FRAC_BITS = fprf_pkg::FracBitsDefault,
  parameter int POWER     = fprf_pkg::PowerDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  fprf_pkg::pow_req_t req,
  output logic              done,
  output logic [63:0]       result
);
  localparam logic [63:0] Qcap = 64'd1 << 62;
  localparam int CntW = $clog2(POWER + 1);

  logic [63:0]     p, m;
  logic [CntW-1:0] cnt;
  logic [1:0]      ph;
  logic            run;
  logic [127:0]    acc, acc_sum, pp_sh;
  logic [31:0]     pa, pb;
  logic [63:0]     pp, nxt;

  // one 32x32 partial product a cycle, four partial products to each 64x64 step
  always_comb begin
    pa = ph[0] ? p[63:32] : p[31:0];
    pb = ph[1] ? m[63:32] : m[31:0];
    pp = {32'd0, pa} * {32'd0, pb};
    case (ph)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    acc_sum = acc + pp_sh;
    if (acc_sum[127:64+FRAC_BITS] != '0) nxt = Qcap;
    else if (acc_sum[63+FRAC_BITS:FRAC_BITS] > Qcap) nxt = Qcap;
    else nxt = acc_sum[63+FRAC_BITS:FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
      ph <= '0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        run <= 1'b1;
        cnt <= '0;
        ph <= '0;
        acc <= '0;
        p <= 64'd1 << FRAC_BITS;
        m <= req.mag;
      end else if (run) begin
        ph <= ph + 1'b1;
        if (ph == 2'd3) begin
          p <= nxt;
          acc <= '0;
          if (cnt == CntW'(POWER - 1)) begin
            run <= 1'b0;
            done <= 1'b1;
          end
          cnt <= cnt + 1'b1;
        end else begin
          acc <= acc_sum;
        end
      end
    end
  end

  assign result = p;
endmodule

// ----- rtl/fprf_div.sv -----
// restoring divider, 128 by 64 bits, one quotient bit a cycle, saturating at 2^62
module fprf_div (
  input  logic         clk,
  input  logic         rst,
  input  logic         go,
  input  logic [127:0] num,
  input  logic [63:0]  den,
  output logic         done,
  output logic [63:0]  quot
);
  localparam logic [63:0] Qcap = 64'd1 << 62;
  logic [127:0] n;
  logic [64:0]  rem, sh;
  logic [63:0]  q;
  logic [6:0]   idx;
  logic         run, over;

  always_comb sh = {rem[63:0], n[127]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        n <= num;
        rem <= '0;
        q <= '0;
        over <= 1'b0;
        idx <= 7'd127;
      end else if (run) begin
        n <= n << 1;
        if (sh >= {1'b0, den}) begin
          rem <= sh - {1'b0, den};
          if (idx >= 7'd62) over <= 1'b1;
          else q[idx[5:0]] <= 1'b1;
        end else begin
          rem <= sh;
        end
        if (idx == 7'd0) begin
          run <= 1'b0;
          done <= 1'b1;
        end
        idx <= idx - 1'b1;
      end
    end
  end

  assign quot = (over || q > Qcap) ? Qcap : q;
endmodule

// ----- rtl/false_position_root_finder_unit.sv -----
// false-position root finder for x^power - 1, top level and sequencer
// an iteration steps through CHECK, FL, FU, DEN, MUL, DGO, DIV, XR, FR and UPD in order; the
// result strobe is registered in the DONE state after the last iteration
// one item at a time, busy from start until the strobe
// result is shown for one cycle on done; the receiver cannot stall
// rst is synchronous: sequencer idles, registers return to 50 and 268
module false_position_root_finder_unit #(
  parameter int FRAC_BITS = fprf_pkg::FracBitsDefault,
  parameter int POWER     = fprf_pkg::PowerDefault
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [fprf_pkg::ValW-1:0] lower_bound,
  input  logic signed [fprf_pkg::ValW-1:0] upper_bound,
  input  logic                         cfg_we,
  input  logic [fprf_pkg::IdxW-1:0]    cfg_index,
  input  logic [fprf_pkg::CfgW-1:0]    cfg_data,
  output logic                         done,
  output logic signed [fprf_pkg::ValW-1:0] root_estimate,
  output logic [fprf_pkg::IterW-1:0]   iterations_used,
  output logic [fprf_pkg::ValW-1:0]    bracket_width,
  output logic [fprf_pkg::StatW-1:0]   status
);
  localparam logic signed [64:0] Lim = 65'sd2 <<< FRAC_BITS;
  localparam logic signed [64:0] One = 65'sd1 <<< FRAC_BITS;

  fprf_pkg::state_t state, state_next;
  logic [fprf_pkg::IterW-1:0] iter_limit, iters;
  logic [fprf_pkg::TolW-1:0]  tol;
  logic signed [64:0] xl, xu, xr, fl, fu, fr, den, diff, xr_raw;
  logic [127:0] prod;
  logic [63:0]  q;
  logic         neg;
  logic [64:0]  width;
  logic [fprf_pkg::StatW-1:0] st;
  logic         tol_stop;

  fprf_pkg::pow_req_t preq;
  logic        pdone, dgo, ddone;
  logic [63:0] pres, dq;
  logic signed [64:0] px, fcalc;
  logic        sx_neg;

  logic [1:0]   mcnt;
  logic [63:0]  fum, dm, mpp;
  logic [31:0]  ma, mb;
  logic [127:0] mpp_sh;

  function automatic logic signed [64:0] clamp2(input logic signed [64:0] v);
    if (v > Lim) return Lim;
    if (v < -Lim) return -Lim;
    return v;
  endfunction

  function automatic logic [63:0] mag(input logic signed [64:0] v);
    return v[64] ? 64'(-v) : v[63:0];
  endfunction

  fprf_mulq #(.FRAC_BITS(FRAC_BITS), .POWER(POWER)) u_pow (
    .clk(clk), .rst(rst), .req(preq), .done(pdone), .result(pres)
  );

  fprf_div u_div (
    .clk(clk), .rst(rst), .go(dgo), .num(prod), .den(mag(den)),
    .done(ddone), .quot(dq)
  );

  // power unit operand for the request issued in the current state
  always_comb begin
    case (state)
      fprf_pkg::S_CHECK: px = xl;
      fprf_pkg::S_FL:    px = xu;
      fprf_pkg::S_XR:    px = xr_raw;
      default:           px = xr;
    endcase
  end

  // sign of the operand whose power is finishing
  always_comb begin
    case (state)
      fprf_pkg::S_FL: sx_neg = xl[64];
      fprf_pkg::S_FU: sx_neg = xu[64];
      default:        sx_neg = xr[64];
    endcase
  end

  always_comb begin
    if (sx_neg && POWER % 2 == 1) fcalc = -$signed({1'b0, pres}) - One;
    else fcalc = $signed({1'b0, pres}) - One;
  end

  always_comb width = (xu > xl) ? 65'(xu - xl) : 65'(xl - xu);

  always_comb tol_stop = (iters != '0) && (width < 65'(tol));

  always_comb begin
    neg = ((fu < 0) != (diff < 0)) != (den < 0);
    xr_raw = clamp2(neg ? xu + $signed({1'b0, q}) : xu - $signed({1'b0, q}));
  end

  // |fu| * |diff| from four 32x32 partial products
  always_comb begin
    fum = mag(fu);
    dm = mag(diff);
    ma = mcnt[0] ? fum[63:32] : fum[31:0];
    mb = mcnt[1] ? dm[63:32] : dm[31:0];
    mpp = {32'd0, ma} * {32'd0, mb};
    case (mcnt)
      2'd0:    mpp_sh = {64'd0, mpp};
      2'd3:    mpp_sh = {mpp, 64'd0};
      default: mpp_sh = {32'd0, mpp, 32'd0};
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      fprf_pkg::S_IDLE:  if (start) state_next = fprf_pkg::S_CHECK;
      fprf_pkg::S_CHECK: state_next = (tol_stop || iters >= iter_limit) ?
                                      fprf_pkg::S_DONE : fprf_pkg::S_FL;
      fprf_pkg::S_FL:    if (pdone) state_next = fprf_pkg::S_FU;
      fprf_pkg::S_FU:    if (pdone) state_next = fprf_pkg::S_DEN;
      fprf_pkg::S_DEN:   state_next = (fl == fu) ? fprf_pkg::S_DONE : fprf_pkg::S_MUL;
      fprf_pkg::S_MUL:   if (mcnt == 2'd3) state_next = fprf_pkg::S_DGO;
      fprf_pkg::S_DGO:   state_next = fprf_pkg::S_DIV;
      fprf_pkg::S_DIV:   if (ddone) state_next = fprf_pkg::S_XR;
      fprf_pkg::S_XR:    state_next = fprf_pkg::S_FR;
      fprf_pkg::S_FR:    if (pdone) state_next = fprf_pkg::S_UPD;
      fprf_pkg::S_UPD:   state_next = (fr == 0) ? fprf_pkg::S_DONE : fprf_pkg::S_CHECK;
      fprf_pkg::S_DONE:  state_next = fprf_pkg::S_IDLE;
      default:           state_next = fprf_pkg::S_IDLE;
    endcase
  end

  // outputs toward the shared power unit and the divider
  always_comb begin
    preq.go = 1'b0;
    preq.mag = mag(px);
    dgo = 1'b0;
    case (state)
      fprf_pkg::S_CHECK: preq.go = !(tol_stop || iters >= iter_limit);
      fprf_pkg::S_FL:    preq.go = pdone;
      fprf_pkg::S_DGO:   dgo = 1'b1;
      fprf_pkg::S_XR:    preq.go = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fprf_pkg::S_IDLE;
      iter_limit <= fprf_pkg::IterLimitReset;
      tol <= fprf_pkg::TolReset;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          fprf_pkg::RegIterLimit: iter_limit <= cfg_data[fprf_pkg::IterW-1:0];
          fprf_pkg::RegTolerance: tol <= cfg_data[fprf_pkg::TolW-1:0];
          default: ;
        endcase
      end
      case (state)
        fprf_pkg::S_IDLE: if (start) begin
          xl <= clamp2(65'(lower_bound));
          xu <= clamp2(65'(upper_bound));
          xr <= clamp2(65'(upper_bound));
          iters <= '0;
        end
        fprf_pkg::S_CHECK: begin
          // tolerance test on the updated bracket comes before the limit
          if (tol_stop) st <= fprf_pkg::StTol;
          else if (iters >= iter_limit) st <= fprf_pkg::StLimit;
        end
        fprf_pkg::S_FL: if (pdone) fl <= fcalc;
        fprf_pkg::S_FU: if (pdone) fu <= fcalc;
        fprf_pkg::S_DEN: begin
          den <= fl - fu;
          diff <= xl - xu;
          prod <= '0;
          mcnt <= '0;
          if (fl == fu) st <= fprf_pkg::StZden;
        end
        fprf_pkg::S_MUL: begin
          prod <= prod + mpp_sh;
          mcnt <= mcnt + 1'b1;
        end
        fprf_pkg::S_DIV: if (ddone) q <= dq;
        fprf_pkg::S_XR: begin
          xr <= xr_raw;
          iters <= iters + 1'b1;
        end
        fprf_pkg::S_FR: if (pdone) fr <= fcalc;
        fprf_pkg::S_UPD: begin
          if (fr == 0) st <= fprf_pkg::StExact;
          else if ((fu < 0) != (fr < 0) && fu != 0) xl <= xr;
          else xu <= xr;
        end
        fprf_pkg::S_DONE: begin
          done <= 1'b1;
          root_estimate <= xr[fprf_pkg::ValW-1:0];
          iterations_used <= iters;
          bracket_width <= width[fprf_pkg::ValW-1:0];
          status <= st;
        end
        default: ;
      endcase
    end
  end

  assign busy = (state != fprf_pkg::S_IDLE);
endmodule

// ----- rtl/fprf_checker.sv -----
// port-level checks for the root finder, bound to the top level
module fprf_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic [fprf_pkg::StatW-1:0] status,
  input logic [fprf_pkg::IterW-1:0] iterations_used
);
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("start not taken");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !$past(done)) else $error("double result beat");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("busy with result");
  a_exact_iter: assert property (@(posedge clk) disable iff (rst)
    done && status == fprf_pkg::StExact |-> iterations_used != 0)
    else $error("exact root without iteration");
endmodule

bind false_position_root_finder_unit fprf_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .status(status), .iterations_used(iterations_used)
);
